### sv/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg - shared types and constants for the ray/triangle hit test
// Register indexes of the configuration port, fixed field widths and the
// latency of the pipelined multiplier.
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int ORG_W   = 32;   // ray origin, signed Q16.16
    localparam int DIR_W   = 18;   // ray direction, signed Q2.16
    localparam int EPS_W   = 16;   // near-zero limit, unsigned Q0.16
    localparam int CFG_W   = 32;   // widest register
    localparam int CFG_IDX_W = 3;

    // partial products are cut into limbs of this width
    localparam int LIMB_W  = 32;
    // operand, partial product, sum and sign stages of rth_mul
    localparam int MUL_LAT = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORG_X = 3'd0,
        CFG_ORG_Y = 3'd1,
        CFG_ORG_Z = 3'd2,
        CFG_DIR_X = 3'd3,
        CFG_DIR_Y = 3'd4,
        CFG_DIR_Z = 3'd5,
        CFG_EPS   = 3'd6
    } t_cfg_idx;

endpackage

### sv/ray_triangle_hit_test.sv
// ----------------------------------------------------------------------------
// ray_triangle_hit_test - forward ray against one triangle per transaction
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+-------------------------------
//   in      | i_in_valid   | o_in_stall   | i_vert_{a,b,c}_{x,y,z}
//   out     | o_out_valid  | i_out_stall  | o_hit
//   cfg     | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
// One triangle enters per cycle while the output is not stalled; the result passes
// through three exact multiplier banks of 4 stages plus 4 add/compare stages.
// Reset is synchronous, clears the valid bits and loads the configuration defaults.
// A stalled valid result freezes the whole pipeline, nothing is lost or doubled.
// ----------------------------------------------------------------------------
module ray_triangle_hit_test
    import rth_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_vert_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert_a_z,
    input  logic signed [COORD_WIDTH-1:0] i_vert_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert_b_z,
    input  logic signed [COORD_WIDTH-1:0] i_vert_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert_c_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert_c_z,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit
);

    localparam int W    = COORD_WIDTH;
    localparam int CW   = ((W > ORG_W) ? W : ORG_W) + 1;   // differences
    localparam int NW   = 2 * CW + 1;                      // cross products
    localparam int NNW  = 2 * NW + 2;                      // n.n
    localparam int DPW  = NW + DIR_W + 2;                  // n.d and weights
    localparam int DSW  = CW + NW + 2;                     // plane distance
    localparam int ESW  = 2 * EPS_W + 1;                   // eps^2, signed
    localparam int LMW  = ESW + NNW;
    localparam int D2W  = 2 * DPW;
    localparam int S2W  = 2 * DSW;
    localparam int MX1  = (LMW > D2W) ? LMW : D2W;
    localparam int CMPW = ((MX1 > S2W) ? MX1 : S2W) + 1;
    localparam int LAT  = 3 * MUL_LAT + 4;

    // configuration registers
    logic signed [ORG_W-1:0] r_org [3];
    logic signed [DIR_W-1:0] r_dir [3];
    logic [EPS_W-1:0]        r_eps;
    logic [2*EPS_W-1:0]      r_eps_sq;

    logic                    en;
    logic [LAT-1:0]          r_vld;

    // stage 1: differences
    logic signed [CW-1:0]    vin  [3][3];
    logic signed [CW-1:0]    r_e1 [3];
    logic signed [CW-1:0]    r_e2 [3];
    logic signed [CW-1:0]    r_oa [3];
    logic signed [CW-1:0]    r_ao [3];
    logic signed [CW-1:0]    r_bo [3];
    logic signed [CW-1:0]    r_co [3];
    logic signed [CW-1:0]    r_oa_d [MUL_LAT+1][3];

    // crosses: normal, then the three weight crosses
    logic signed [CW-1:0]    cu [4][3];
    logic signed [CW-1:0]    cv [4][3];
    logic signed [2*CW-1:0]  pa [4][3];
    logic signed [2*CW-1:0]  pb [4][3];
    logic signed [NW-1:0]    r_cr [4][3];

    // second products
    logic signed [2*NW-1:0]       p_nn [3];
    logic signed [NW+DIR_W-1:0]   p_dv [4][3];
    logic signed [CW+NW-1:0]      p_ds [3];
    logic signed [NNW-1:0]        r_nn;
    logic signed [DPW-1:0]        r_dv [4];
    logic signed [DSW-1:0]        r_dist;

    // third products
    logic signed [LMW-1:0]   p_lim;
    logic signed [D2W-1:0]   p_dp2;
    logic signed [S2W-1:0]   p_ds2;
    logic                    early_miss;
    logic [MUL_LAT-1:0]      r_em;
    logic                    miss;
    logic                    r_hit;

    assign en         = !r_vld[LAT-1] || !i_out_stall;
    assign o_in_stall = !en;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= DIR_W'(65536);
            r_dir[1] <= '0;
            r_dir[2] <= '0;
            r_eps    <= EPS_W'(1);
            r_eps_sq <= (2*EPS_W)'(1);
        end else begin
            r_eps_sq <= (2*EPS_W)'(r_eps) * (2*EPS_W)'(r_eps);
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ORG_X: r_org[0] <= i_cfg_data[ORG_W-1:0];
                    CFG_ORG_Y: r_org[1] <= i_cfg_data[ORG_W-1:0];
                    CFG_ORG_Z: r_org[2] <= i_cfg_data[ORG_W-1:0];
                    CFG_DIR_X: r_dir[0] <= i_cfg_data[DIR_W-1:0];
                    CFG_DIR_Y: r_dir[1] <= i_cfg_data[DIR_W-1:0];
                    CFG_DIR_Z: r_dir[2] <= i_cfg_data[DIR_W-1:0];
                    CFG_EPS:   r_eps    <= i_cfg_data[EPS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    assign vin[0][0] = CW'(i_vert_a_x);
    assign vin[0][1] = CW'(i_vert_a_y);
    assign vin[0][2] = CW'(i_vert_a_z);
    assign vin[1][0] = CW'(i_vert_b_x);
    assign vin[1][1] = CW'(i_vert_b_y);
    assign vin[1][2] = CW'(i_vert_b_z);
    assign vin[2][0] = CW'(i_vert_c_x);
    assign vin[2][1] = CW'(i_vert_c_y);
    assign vin[2][2] = CW'(i_vert_c_z);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= vin[1][k] - vin[0][k];
                r_e2[k] <= vin[2][k] - vin[0][k];
                r_oa[k] <= CW'(r_org[k]) - vin[0][k];
                r_ao[k] <= vin[0][k] - CW'(r_org[k]);
                r_bo[k] <= vin[1][k] - CW'(r_org[k]);
                r_co[k] <= vin[2][k] - CW'(r_org[k]);
                r_oa_d[0][k] <= r_oa[k];
                for (int s = 1; s <= MUL_LAT; s++) begin
                    r_oa_d[s][k] <= r_oa_d[s-1][k];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cu[0][k] = r_e1[k];
            cv[0][k] = r_e2[k];
            cu[1][k] = r_ao[k];
            cv[1][k] = r_bo[k];
            cu[2][k] = r_bo[k];
            cv[2][k] = r_co[k];
            cu[3][k] = r_co[k];
            cv[3][k] = r_ao[k];
        end
    end

    // first bank: four cross products
    for (genvar q = 0; q < 4; q++) begin : g_cross
        for (genvar k = 0; k < 3; k++) begin : g_comp
            rth_mul #(.AW(CW), .BW(CW)) u_pa (
                .i_clk(i_clk), .i_en(en),
                .i_a(cu[q][(k+1)%3]), .i_b(cv[q][(k+2)%3]), .o_p(pa[q][k])
            );
            rth_mul #(.AW(CW), .BW(CW)) u_pb (
                .i_clk(i_clk), .i_en(en),
                .i_a(cu[q][(k+2)%3]), .i_b(cv[q][(k+1)%3]), .o_p(pb[q][k])
            );
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_cr[q][k] <= NW'(pa[q][k]) - NW'(pb[q][k]);
                end
            end
        end
    end

    // second bank: n.n, n.d, weights against d, plane distance
    for (genvar k = 0; k < 3; k++) begin : g_dot
        rth_mul #(.AW(NW), .BW(NW)) u_nn (
            .i_clk(i_clk), .i_en(en),
            .i_a(r_cr[0][k]), .i_b(r_cr[0][k]), .o_p(p_nn[k])
        );
        rth_mul #(.AW(CW), .BW(NW)) u_ds (
            .i_clk(i_clk), .i_en(en),
            .i_a(r_oa_d[MUL_LAT][k]), .i_b(r_cr[0][k]), .o_p(p_ds[k])
        );
        for (genvar q = 0; q < 4; q++) begin : g_dv
            rth_mul #(.AW(NW), .BW(DIR_W)) u_dv (
                .i_clk(i_clk), .i_en(en),
                .i_a(r_cr[q][k]), .i_b(r_dir[k]), .o_p(p_dv[q][k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nn   <= NNW'(p_nn[0]) + NNW'(p_nn[1]) + NNW'(p_nn[2]);
            r_dist <= DSW'(p_ds[0]) + DSW'(p_ds[1]) + DSW'(p_ds[2]);
            for (int q = 0; q < 4; q++) begin
                r_dv[q] <= DPW'(p_dv[q][0]) + DPW'(p_dv[q][1]) + DPW'(p_dv[q][2]);
            end
        end
    end

    // sign tests: degenerate triangle, parallel ray, plane behind origin, weight against n.d
    always_comb begin
        early_miss = (r_nn == '0) || (r_dv[0] == '0);
        if ((r_dist != '0) && (r_dist[DSW-1] == r_dv[0][DPW-1])) begin
            early_miss = 1'b1;
        end
        for (int q = 1; q < 4; q++) begin
            if ((r_dv[q] != '0) && (r_dv[q][DPW-1] != r_dv[0][DPW-1])) begin
                early_miss = 1'b1;
            end
        end
    end

    // third bank: squares and eps^2 * n.n
    rth_mul #(.AW(ESW), .BW(NNW)) u_lim (
        .i_clk(i_clk), .i_en(en),
        .i_a($signed({1'b0, r_eps_sq})), .i_b(r_nn), .o_p(p_lim)
    );
    rth_mul #(.AW(DPW), .BW(DPW)) u_dp2 (
        .i_clk(i_clk), .i_en(en),
        .i_a(r_dv[0]), .i_b(r_dv[0]), .o_p(p_dp2)
    );
    rth_mul #(.AW(DSW), .BW(DSW)) u_ds2 (
        .i_clk(i_clk), .i_en(en),
        .i_a(r_dist), .i_b(r_dist), .o_p(p_ds2)
    );

    assign miss = r_em[MUL_LAT-1]
               || (CMPW'(p_dp2) < CMPW'(p_lim))
               || (CMPW'(p_ds2) < CMPW'(p_lim));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_em  <= {r_em[MUL_LAT-2:0], early_miss};
            r_hit <= !miss;
        end
    end

    assign o_out_valid = r_vld[LAT-1];
    assign o_hit       = r_hit;

endmodule

### sv/rth_mul.sv
// ----------------------------------------------------------------------------
// rth_mul - pipelined exact signed multiplier
// Sign and magnitude split, 32x32 limb partial products, shifted sum and
// sign restore, one register stage each. Advances only while i_en is high.
// ----------------------------------------------------------------------------
module rth_mul
    import rth_pkg::*;
#(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);

    localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
    localparam int SW = (NA + NB) * LIMB_W;
    localparam int PW = AW + BW;

    logic [AW-1:0]            a_abs;
    logic [BW-1:0]            b_abs;
    logic [NA*LIMB_W-1:0]     r_ma;
    logic [NB*LIMB_W-1:0]     r_mb;
    logic                     r_s1;
    logic [2*LIMB_W-1:0]      r_pp [NA*NB];
    logic                     r_s2;
    logic [SW-1:0]            acc;
    logic [PW-1:0]            r_sum;
    logic                     r_s3;
    logic signed [PW-1:0]     r_p;

    assign a_abs = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
    assign b_abs = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (SW'(r_pp[i*NB+j]) << (LIMB_W * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma <= (NA*LIMB_W)'(a_abs);
            r_mb <= (NB*LIMB_W)'(b_abs);
            r_s1 <= i_a[AW-1] ^ i_b[BW-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= (2*LIMB_W)'(r_ma[i*LIMB_W +: LIMB_W])
                                  * (2*LIMB_W)'(r_mb[j*LIMB_W +: LIMB_W]);
                end
            end
            r_s2  <= r_s1;
            r_sum <= acc[PW-1:0];
            r_s3  <= r_s2;
            r_p   <= r_s3 ? -$signed(r_sum) : $signed(r_sum);
        end
    end

    assign o_p = r_p;

endmodule

### sv/rth_checker.sv
// ----------------------------------------------------------------------------
// rth_checker - port-level checks for ray_triangle_hit_test
// Watches the handshake and the stall coupling between the two channels.
// ----------------------------------------------------------------------------
module rth_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_hit
);

    // input is held back only by a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_hit))
        else $error("result changed while stalled");

endmodule

bind ray_triangle_hit_test rth_checker u_rth_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_hit      (o_hit)
);
